FILE: rtl/core/lcd4w_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the phase decode function for the 4-bit character LCD writer.
// Depends on nothing; every other file of the block imports it.
package lcd4w_pkg;

	localparam int unsigned CLOCKS_PER_MS_DEFAULT = 50000;

	localparam int HOLD_W = 5;
	localparam int IDX_W  = 5;

	typedef enum logic [2:0] {
		KIND_COMMAND = 3'd0,
		KIND_DATA    = 3'd1,
		KIND_CURSOR  = 3'd2,
		KIND_CLEAR   = 3'd3,
		KIND_INIT    = 3'd4
	} item_kind_t;

	localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
	localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
	localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
	localparam logic [7:0] CMD_CLEAR        = 8'h01;
	localparam logic [7:0] CMD_DDRAM_ROW0   = 8'h80;
	localparam logic [7:0] CMD_DDRAM_ROW1   = 8'hC0;
	localparam logic [3:0] NIB_WAKE         = 4'h3;
	localparam logic [3:0] NIB_FOUR_BIT     = 4'h2;

	localparam logic [HOLD_W-1:0] HOLD_STROBE    = 5'd1;
	localparam logic [HOLD_W-1:0] HOLD_POWER_UP  = 5'd20;
	localparam logic [HOLD_W-1:0] HOLD_WAKE_1    = 5'd6;
	localparam logic [HOLD_W-1:0] HOLD_WAKE_2    = 5'd2;
	localparam logic [HOLD_W-1:0] EXTRA_CLEAR    = 5'd2;
	localparam logic [HOLD_W-1:0] HOLD_MAX       = 5'd20;

	localparam logic [IDX_W-1:0] INIT_NIB_FIRST = 5'd1;
	localparam logic [IDX_W-1:0] INIT_NIB_LAST  = 5'd8;
	localparam logic [IDX_W-1:0] INIT_CMD_FIRST = 5'd9;
	localparam logic [IDX_W-1:0] INIT_LAST_IDX  = 5'd24;

	typedef struct packed {
		item_kind_t kind;
		logic [7:0] cmd_byte;
	} item_t;

	typedef struct packed {
		logic              rs;
		logic              en;
		logic [3:0]        nib;
		logic [HOLD_W-1:0] hold;
		logic              last;
	} phase_t;

	// One byte goes out as high nibble then low nibble, each as an EN-high and an EN-low phase.
	function automatic phase_t byte_phase(input logic [7:0] b, input logic rs,
			input logic [1:0] sub, input logic [HOLD_W-1:0] extra);
		phase_t p;
		p.rs   = rs;
		p.en   = ~sub[0];
		p.nib  = sub[1] ? b[3:0] : b[7:4];
		p.hold = (sub == 2'd3) ? (HOLD_STROBE + extra) : HOLD_STROBE;
		p.last = (sub == 2'd3);
		return p;
	endfunction

	function automatic phase_t phase_decode(input item_kind_t kind, input logic [7:0] cmd,
			input logic rs, input logic [IDX_W-1:0] idx);
		phase_t            p;
		logic [IDX_W-1:0]  j;
		logic [1:0]        sel;
		logic [7:0]        b;
		logic [HOLD_W-1:0] extra;
		p     = '0;
		j     = '0;
		sel   = '0;
		b     = '0;
		extra = '0;
		if (kind == KIND_INIT) begin
			if (idx == '0) begin
				p.rs   = rs;
				p.en   = 1'b0;
				p.nib  = 4'h0;
				p.hold = HOLD_POWER_UP;
				p.last = 1'b0;
			end else if (idx <= INIT_NIB_LAST) begin
				j     = idx - INIT_NIB_FIRST;
				sel   = j[2:1];
				p.rs  = rs;
				p.en  = ~j[0];
				p.nib = (sel == 2'd3) ? NIB_FOUR_BIT : NIB_WAKE;
				if (j[0]) begin
					case (sel)
						2'd0:    p.hold = HOLD_WAKE_1;
						2'd1:    p.hold = HOLD_WAKE_2;
						default: p.hold = HOLD_STROBE;
					endcase
				end else begin
					p.hold = HOLD_STROBE;
				end
				p.last = 1'b0;
			end else begin
				j   = idx - INIT_CMD_FIRST;
				sel = j[3:2];
				case (sel)
					2'd0:    b = CMD_FUNCTION_SET;
					2'd1:    b = CMD_DISPLAY_ON;
					2'd2:    b = CMD_ENTRY_MODE;
					default: b = CMD_CLEAR;
				endcase
				extra  = (sel == 2'd3) ? EXTRA_CLEAR : '0;
				p      = byte_phase(b, 1'b0, j[1:0], extra);
				p.last = (idx == INIT_LAST_IDX);
			end
		end else begin
			extra = (kind == KIND_CLEAR) ? EXTRA_CLEAR : '0;
			p     = byte_phase(cmd, rs, idx[1:0], extra);
		end
		return p;
	endfunction

endpackage

FILE: rtl/core/lcd4w_input_stage.sv
`timescale 1ns / 1ps
// Input register of the LCD writer: takes one item transaction and forms its command byte.
// Depends on lcd4w_pkg.
module lcd4w_input_stage
	import lcd4w_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [2:0] kind,
	input  logic [7:0] byte_value,
	input  logic       cursor_row,
	input  logic [5:0] cursor_col,
	output logic       valid_s1,
	output item_t      item_s1,
	input  logic       take
);

	logic       accept;
	logic       known;
	logic [7:0] cmd_byte;

	assign item_stall = valid_s1 & ~take;
	assign accept     = item_valid & ~item_stall;

	always_comb begin
		known    = 1'b1;
		cmd_byte = byte_value;
		case (kind)
			KIND_COMMAND, KIND_DATA: cmd_byte = byte_value;
			KIND_CURSOR: cmd_byte = (cursor_row ? CMD_DDRAM_ROW1 : CMD_DDRAM_ROW0)
				+ {2'b00, cursor_col};
			KIND_CLEAR:  cmd_byte = CMD_CLEAR;
			KIND_INIT:   cmd_byte = CMD_CLEAR;
			default: begin
				known    = 1'b0;
				cmd_byte = byte_value;
			end
		endcase
	end

	// Unused kinds are accepted and dropped here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || take) begin
			valid_s1 <= accept & known;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && known) begin
			item_s1.kind     <= item_kind_t'(kind);
			item_s1.cmd_byte <= cmd_byte;
		end
	end

endmodule

FILE: rtl/core/lcd4w_hold_timer.sv
`timescale 1ns / 1ps
// Hold timer: counts the milliseconds of the current pin phase in clock cycles.
// Depends on lcd4w_pkg.
module lcd4w_hold_timer
	import lcd4w_pkg::*;
#(
	parameter int unsigned CLOCKS_PER_MS = CLOCKS_PER_MS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic [HOLD_W-1:0] hold,
	output logic              done
);

	localparam int CNT_W = (CLOCKS_PER_MS > 1) ? $clog2(CLOCKS_PER_MS) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CLOCKS_PER_MS - 1);

	logic [HOLD_W-1:0] ms_q;
	logic [CNT_W-1:0]  cyc_q;

	assign done = (ms_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q  <= '0;
			cyc_q <= '0;
		end else if (load) begin
			ms_q  <= hold;
			cyc_q <= '0;
		end else if (!done) begin
			if (cyc_q == CNT_LAST) begin
				cyc_q <= '0;
				ms_q  <= ms_q - 1'b1;
			end else begin
				cyc_q <= cyc_q + 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/lcd4w_phase_seq.sv
`timescale 1ns / 1ps
// Phase sequencer: walks the pin phases of the current item and tracks the RS level.
// Depends on lcd4w_pkg.
module lcd4w_phase_seq
	import lcd4w_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   valid_s1,
	input  item_t  item_s1,
	input  logic   tmr_done,
	input  logic   out_free,
	output logic   take,
	output logic   emit,
	output phase_t phase
);

	logic             busy_q;
	item_kind_t       kind_q;
	logic [7:0]       cmd_q;
	logic             rs_q;
	logic [IDX_W-1:0] idx_q;
	logic             rs_level_q;

	assign phase = phase_decode(kind_q, cmd_q, rs_q, idx_q);
	assign emit  = busy_q & tmr_done & out_free;
	assign take  = valid_s1 & (~busy_q | (emit & phase.last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			idx_q      <= '0;
			rs_level_q <= 1'b0;
		end else if (take) begin
			busy_q     <= 1'b1;
			idx_q      <= '0;
			rs_level_q <= (item_s1.kind == KIND_DATA);
		end else if (emit) begin
			busy_q <= ~phase.last;
			idx_q  <= idx_q + 1'b1;
		end
	end

	// Init keeps the RS level that the previous item left.
	always_ff @(posedge clk) begin
		if (take) begin
			kind_q <= item_s1.kind;
			cmd_q  <= item_s1.cmd_byte;
			rs_q   <= (item_s1.kind == KIND_INIT) ? rs_level_q : (item_s1.kind == KIND_DATA);
		end
	end

endmodule

FILE: rtl/core/char_lcd_4bit_writer_core.sv
`timescale 1ns / 1ps
// When idle, an item's first phase is offered after the input, sequencer and output registers.
// Each later phase issues once the hold timer has run out the previous phase's hold_ms and the
// output is free; a command or data item takes about 4 ms, clear 6 ms and init 52 ms.
// A new item is taken into the input register while the current one is still being sent.
// Reset clears the valid flags, the hold timer and the stored RS level to zero.
module char_lcd_4bit_writer_core
	import lcd4w_pkg::*;
#(
	parameter int unsigned CLOCKS_PER_MS = CLOCKS_PER_MS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [2:0]        kind,
	input  logic [7:0]        byte_value,
	input  logic              cursor_row,
	input  logic [5:0]        cursor_col,
	output logic              phase_valid,
	input  logic              phase_stall,
	output logic              rs_pin,
	output logic              enable_pin,
	output logic [3:0]        data_nibble,
	output logic [HOLD_W-1:0] hold_ms,
	output logic              last_phase
);

	logic   valid_s1;
	item_t  item_s1;
	logic   take;
	logic   emit;
	logic   tmr_done;
	logic   out_free;
	phase_t phase;
	phase_t phase_q;
	logic   out_valid_q;

	assign out_free = ~out_valid_q | ~phase_stall;

	lcd4w_input_stage u_input (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.kind       (kind),
		.byte_value (byte_value),
		.cursor_row (cursor_row),
		.cursor_col (cursor_col),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1),
		.take       (take)
	);

	lcd4w_phase_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.tmr_done (tmr_done),
		.out_free (out_free),
		.take     (take),
		.emit     (emit),
		.phase    (phase)
	);

	lcd4w_hold_timer #(
		.CLOCKS_PER_MS (CLOCKS_PER_MS)
	) u_timer (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (emit),
		.hold   (phase.hold),
		.done   (tmr_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!phase_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			phase_q <= phase;
		end
	end

	assign phase_valid = out_valid_q;
	assign rs_pin      = phase_q.rs;
	assign enable_pin  = phase_q.en;
	assign data_nibble = phase_q.nib;
	assign hold_ms     = phase_q.hold;
	assign last_phase  = phase_q.last;

	// Every phase holds for at least one millisecond, so two phases never issue back to back.
	a_paced_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> !emit)
		else $error("Two phases issued in consecutive cycles.");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("Input stalled with an empty input register.");

	a_hold_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_valid |-> (hold_ms != '0) && (hold_ms <= HOLD_MAX))
		else $error("Phase hold out of range.");

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (!emit || phase.last))
		else $error("New item taken while the current one was still being sent.");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for char_lcd_4bit_writer_core: directed and random LCD items in,
// pin phases out, checked against an in-bench phase predictor. Depends on lcd4w_pkg and the RTL.
module tb_top;
	import lcd4w_pkg::*;

	localparam int unsigned MS_CYCLES = 1000;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int HOLD_OFF_CYCLES = 8 * MS_CYCLES;
	localparam int RANDOM_ITEMS = 85;

	typedef struct {
		logic [2:0] kind;
		logic [7:0] byte_value;
		logic       cursor_row;
		logic [5:0] cursor_col;
	} lcd_item_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_stall;
	logic [2:0]        kind = '0;
	logic [7:0]        byte_value = '0;
	logic              cursor_row = 1'b0;
	logic [5:0]        cursor_col = '0;
	logic              phase_valid;
	logic              phase_stall = 1'b0;
	logic              rs_pin;
	logic              enable_pin;
	logic [3:0]        data_nibble;
	logic [HOLD_W-1:0] hold_ms;
	logic              last_phase;

	lcd_item_t pending_items[$];
	phase_t    pending_phases[$];
	logic      rs_state = 1'b0;
	logic      tail_mode = 1'b0;
	logic      hold_done = 1'b0;
	logic      idle_ok;
	int        gap_left = 0;
	int        stall_left = 0;
	int        hold_left = 0;
	int        items_taken = 0;
	int        phases_checked = 0;
	int        errors = 0;
	int        cycle_no = 0;
	int        quiet_cycles = 0;
	int        kind_seen[0:7];

	char_lcd_4bit_writer_core #(.CLOCKS_PER_MS(MS_CYCLES)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.kind(kind),
		.byte_value(byte_value),
		.cursor_row(cursor_row),
		.cursor_col(cursor_col),
		.phase_valid(phase_valid),
		.phase_stall(phase_stall),
		.rs_pin(rs_pin),
		.enable_pin(enable_pin),
		.data_nibble(data_nibble),
		.hold_ms(hold_ms),
		.last_phase(last_phase)
	);

	always #5 clk = ~clk;

	assign idle_ok = !tail_mode && ((cycle_no % 20000) < 15000);

	task automatic push_phase(input logic rs, input logic en, input logic [3:0] nib,
			input logic [HOLD_W-1:0] hold);
		pending_phases.push_back('{rs: rs, en: en, nib: nib, hold: hold, last: 1'b0});
	endtask

	task automatic push_nibble(input logic rs, input logic [3:0] nib,
			input logic [HOLD_W-1:0] extra);
		push_phase(rs, 1'b1, nib, 5'd1);
		push_phase(rs, 1'b0, nib, 5'd1 + extra);
	endtask

	task automatic push_byte(input logic rs, input logic [7:0] b, input logic [HOLD_W-1:0] extra);
		push_nibble(rs, b[7:4], '0);
		push_nibble(rs, b[3:0], extra);
	endtask

	task automatic queue_item_phases(input logic [2:0] k, input logic [7:0] bv, input logic row,
			input logic [5:0] col);
		int         first_new;
		logic [7:0] addr;
		first_new = pending_phases.size();
		addr = (row ? CMD_DDRAM_ROW1 : CMD_DDRAM_ROW0) + {2'b00, col};
		case (item_kind_t'(k))
			KIND_COMMAND: begin
				push_byte(1'b0, bv, '0);
				rs_state = 1'b0;
			end
			KIND_DATA: begin
				push_byte(1'b1, bv, '0);
				rs_state = 1'b1;
			end
			KIND_CURSOR: begin
				push_byte(1'b0, addr, '0);
				rs_state = 1'b0;
			end
			KIND_CLEAR: begin
				push_byte(1'b0, CMD_CLEAR, EXTRA_CLEAR);
				rs_state = 1'b0;
			end
			KIND_INIT: begin
				push_phase(rs_state, 1'b0, 4'h0, HOLD_POWER_UP);
				push_nibble(rs_state, NIB_WAKE, 5'd5);
				push_nibble(rs_state, NIB_WAKE, 5'd1);
				push_nibble(rs_state, NIB_WAKE, '0);
				push_nibble(rs_state, NIB_FOUR_BIT, '0);
				push_byte(1'b0, CMD_FUNCTION_SET, '0);
				push_byte(1'b0, CMD_DISPLAY_ON, '0);
				push_byte(1'b0, CMD_ENTRY_MODE, '0);
				push_byte(1'b0, CMD_CLEAR, EXTRA_CLEAR);
				rs_state = 1'b0;
			end
			default: begin
			end
		endcase
		if (pending_phases.size() > first_new)
			pending_phases[pending_phases.size() - 1].last = 1'b1;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	function automatic lcd_item_t make_item(input logic [2:0] k, input logic [7:0] bv,
			input logic row, input logic [5:0] col);
		lcd_item_t it;
		it.kind = k;
		it.byte_value = bv;
		it.cursor_row = row;
		it.cursor_col = col;
		return it;
	endfunction

	always @(posedge clk or negedge arst_n) begin : item_driver
		lcd_item_t nxt;
		if (!arst_n) begin
			item_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (item_valid && !item_stall) begin
				queue_item_phases(kind, byte_value, cursor_row, cursor_col);
				kind_seen[kind] = kind_seen[kind] + 1;
				items_taken <= items_taken + 1;
			end
			tail_mode <= (pending_items.size() <= 10);
			if (!item_valid || !item_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					item_valid <= 1'b0;
				end else if (pending_items.size() == 0) begin
					item_valid <= 1'b0;
				end else if (idle_ok && $urandom_range(0, 5) == 0) begin
					gap_left <= $urandom_range(0, 10);
					item_valid <= 1'b0;
				end else begin
					nxt = pending_items.pop_front();
					kind <= nxt.kind;
					byte_value <= nxt.byte_value;
					cursor_row <= nxt.cursor_row;
					cursor_col <= nxt.cursor_col;
					item_valid <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			phase_stall <= 1'b1;
		end else if (!hold_done && items_taken >= 30) begin
			hold_left <= HOLD_OFF_CYCLES;
			hold_done <= 1'b1;
			phase_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			phase_stall <= 1'b1;
		end else if (idle_ok && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 10);
			phase_stall <= 1'b1;
		end else begin
			phase_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : phase_monitor
		phase_t want;
		if (arst_n && phase_valid && !phase_stall) begin
			if (pending_phases.size() == 0) begin
				$display("%0t: unexpected phase, expected none, actual %s",
					$time, $sformatf("rs=%0b en=%0b nib=%h hold=%0d last=%0b",
					rs_pin, enable_pin, data_nibble, hold_ms, last_phase));
				errors++;
			end else begin
				want = pending_phases.pop_front();
				check_field("rs_pin", int'(want.rs), int'(rs_pin));
				check_field("enable_pin", int'(want.en), int'(enable_pin));
				check_field("data_nibble", int'(want.nib), int'(data_nibble));
				check_field("hold_ms", int'(want.hold), int'(hold_ms));
				check_field("last_phase", int'(want.last), int'(last_phase));
				phases_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if ((item_valid && !item_stall) || (phase_valid && !phase_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		int r;
		int counted;
		for (int i = 0; i < 8; i++)
			kind_seen[i] = 0;

		// Directed part: byte extremes, init with both RS levels, cursor corners, ignored kinds.
		pending_items.push_back(make_item(KIND_INIT, 8'h00, 1'b0, 6'd0));
		pending_items.push_back(make_item(KIND_COMMAND, 8'h00, 1'b0, 6'd0));
		pending_items.push_back(make_item(KIND_COMMAND, 8'hFF, 1'b1, 6'd63));
		pending_items.push_back(make_item(KIND_DATA, 8'h00, 1'b0, 6'd0));
		pending_items.push_back(make_item(KIND_DATA, 8'hFF, 1'b1, 6'd63));
		pending_items.push_back(make_item(3'd5, 8'h12, 1'b0, 6'd5));
		pending_items.push_back(make_item(3'd6, 8'hAB, 1'b1, 6'd40));
		pending_items.push_back(make_item(3'd7, 8'hFF, 1'b1, 6'd63));
		pending_items.push_back(make_item(KIND_INIT, 8'hFF, 1'b1, 6'd63));
		pending_items.push_back(make_item(KIND_DATA, 8'h5A, 1'b0, 6'd0));
		pending_items.push_back(make_item(KIND_CURSOR, 8'h00, 1'b0, 6'd0));
		pending_items.push_back(make_item(KIND_CURSOR, 8'h00, 1'b1, 6'd39));
		pending_items.push_back(make_item(KIND_CURSOR, 8'hFF, 1'b1, 6'd63));
		pending_items.push_back(make_item(KIND_CURSOR, 8'h00, 1'b0, 6'd63));
		pending_items.push_back(make_item(KIND_CLEAR, 8'hFF, 1'b1, 6'd63));
		pending_items.push_back(make_item(KIND_DATA, 8'hA5, 1'b0, 6'd0));
		pending_items.push_back(make_item(KIND_CLEAR, 8'h00, 1'b0, 6'd0));

		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 2)
				pending_items.push_back(make_item(KIND_INIT, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 6'($urandom_range(0, 63))));
			else if (r < 5)
				pending_items.push_back(make_item(3'($urandom_range(5, 7)),
					8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					6'($urandom_range(0, 63))));
			else if (r < 15)
				pending_items.push_back(make_item(KIND_CLEAR, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 6'($urandom_range(0, 63))));
			else if (r < 35)
				pending_items.push_back(make_item(KIND_CURSOR, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 6'($urandom_range(0, 63))));
			else if (r < 60)
				pending_items.push_back(make_item(KIND_COMMAND, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 6'($urandom_range(0, 63))));
			else
				pending_items.push_back(make_item(KIND_DATA, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 6'($urandom_range(0, 63))));
			if (r < 2 || r >= 5)
				counted++;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || item_valid)
			@(posedge clk);
		while (pending_phases.size() != 0)
			@(posedge clk);
		repeat (21 * MS_CYCLES) @(posedge clk);

		$display("Checked %0d phases from %0d command, %0d data, %0d cursor, %0d clear, %0d init.",
			phases_checked, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
			kind_seen[4]);
		$display("Also sent %0d ignored items and held the output off for %0d cycles once.",
			kind_seen[5] + kind_seen[6] + kind_seen[7], HOLD_OFF_CYCLES);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/lcd4w_pkg.sv
rtl/core/lcd4w_input_stage.sv
rtl/core/lcd4w_hold_timer.sv
rtl/core/lcd4w_phase_seq.sv
rtl/core/char_lcd_4bit_writer_core.sv
verif/tb_top.sv
